// ----- hw/rtl/box_blur_3x3_rgb_defines.svh -----
// Assertion macros used by the checker file.
`ifndef BOX_BLUR_3X3_RGB_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_DEFINES_SVH

// same-cycle implication, off during reset
`define BBR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define BBR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also looks at reset itself
`define BBR_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bbr_pkg.sv -----
`timescale 1ns / 1ps
package bbr_pkg;

   localparam int PIX_W      = 24;
   localparam int LANE_W     = 12;
   localparam int SUM_W      = 3 * LANE_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // result queue
   localparam int RQ_DEPTH = 8;
   localparam int RQ_PTR_W = 3;
   localparam int RQ_CNT_W = 4;

   // ceil(2^16 / 9); exact floor(x / 9) for x < 4096
   localparam logic [12:0] DIV9_RECIP = 13'd7282;

   // three 12-bit lanes: [11:0] red, [23:12] green, [35:24] blue
   typedef logic [SUM_W-1:0] lanes_type;

   typedef struct packed {
      lanes_type sum;
      logic      frame_end;
      logic      run_end;
   } rq_entry_type;

   typedef struct packed {
      logic         v0;
      logic         v1;
      rq_entry_type e0;
      rq_entry_type e1;
   } rq_push_type;

   // which results an item produces
   typedef struct packed {
      logic main;     // (c-1, r-1) from left + center + right columns
      logic tail;     // extra right-edge result at the last column
      logic triple;   // single-column frame
      logic left_p1;  // c == 1: left column clamps onto column 0
      logic fe;       // item belongs to the flush row
   } res_ctl_type;

   function automatic lanes_type spread(input logic [PIX_W-1:0] p);
      return {4'd0, p[23:16], 4'd0, p[15:8], 4'd0, p[7:0]};
   endfunction

   function automatic logic [1:0] res_count(input res_ctl_type c);
      return {1'b0, c.main | c.triple} + {1'b0, c.tail};
   endfunction

   function automatic logic [7:0] div9(input logic [LANE_W-1:0] x);
      logic [LANE_W+12:0] prod;
      prod = {13'd0, x} * {12'd0, DIV9_RECIP};
      return prod[23:16];
   endfunction

endpackage

// ----- hw/rtl/bbr_if.sv -----
`timescale 1ns / 1ps
interface bbr_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;

   modport source (output valid, output mode, output in_red, output in_green,
                   output in_blue, input ready);
   modport sink (input valid, input mode, input in_red, input in_green,
                 input in_blue, output ready);
endinterface

interface bbr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       frame_end;
   logic       run_end;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output frame_end, output run_end, input ready);
   modport sink (input valid, input out_red, input out_green, input out_blue,
                 input frame_end, input run_end, output ready);
endinterface

// ----- hw/rtl/bbr_rsp_queue.sv -----
`timescale 1ns / 1ps
module bbr_rsp_queue
   import bbr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  rq_push_type         push,
   output logic [RQ_CNT_W-1:0] level,
   bbr_rsp_if.source           rsp_ch
);

   rq_entry_type        slot_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_red_ff, out_red_in;
   logic [7:0]          out_green_ff, out_green_in;
   logic [7:0]          out_blue_ff, out_blue_in;
   logic                out_fe_ff, out_fe_in;
   logic                out_re_ff, out_re_in;

   rq_entry_type head;
   logic         pop;
   logic [1:0]   push_n;

   assign head   = slot_ff[rd_ptr_ff];
   assign pop    = (cnt_ff != '0) && (!out_valid_ff || rsp_ch.ready);
   assign push_n = {1'b0, push.v0} + {1'b0, push.v1};

   always_comb begin
      wr_ptr_in    = wr_ptr_ff + RQ_PTR_W'(push_n);
      rd_ptr_in    = pop ? rd_ptr_ff + RQ_PTR_W'(1) : rd_ptr_ff;
      cnt_in       = cnt_ff + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);
      out_valid_in = pop ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      out_red_in   = out_red_ff;
      out_green_in = out_green_ff;
      out_blue_in  = out_blue_ff;
      out_fe_in    = out_fe_ff;
      out_re_in    = out_re_ff;
      if (pop) begin
         out_red_in   = div9(head.sum[LANE_W-1:0]);
         out_green_in = div9(head.sum[2*LANE_W-1:LANE_W]);
         out_blue_in  = div9(head.sum[3*LANE_W-1:2*LANE_W]);
         out_fe_in    = head.frame_end;
         out_re_in    = head.run_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         slot_ff[wr_ptr_ff] <= push.e0;
      end
      if (push.v1) begin
         slot_ff[wr_ptr_ff + RQ_PTR_W'(1)] <= push.e1;
      end
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
      out_fe_ff    <= out_fe_in;
      out_re_ff    <= out_re_in;
   end

   assign level            = cnt_ff;
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_red   = out_red_ff;
   assign rsp_ch.out_green = out_green_ff;
   assign rsp_ch.out_blue  = out_blue_ff;
   assign rsp_ch.frame_end = out_fe_ff;
   assign rsp_ch.run_end   = out_re_ff;

endmodule

// ----- hw/rtl/box_blur_3x3_rgb.sv -----
`timescale 1ns / 1ps
// Streaming 3x3 RGB box blur. Takes one item per clock while the result
// queue has room. An item's first result passes stages 1 and 2, the queue
// and the output register; a second one (right frame edge) follows it.
// Results trail the pixel stream by one row and one column.
// Reset (sync, active high) clears counters, window, pipeline and queue;
// the line store has no clearing pass, stale entries never reach a result.
module box_blur_3x3_rgb
   import bbr_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   bbr_req_if.sink               req_ch,
   bbr_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WD_W  = $clog2(MAX_WIDTH + 1);
   localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
   localparam int W_RST = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
   localparam int H_RST = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;
   localparam int CR_W  = RQ_CNT_W + 1;
   localparam int MEM_W = 2 * PIX_W;

   // ------------------------------------------------------------------
   // Frame geometry. Stored already clamped to 1..MAX.
   // ------------------------------------------------------------------
   logic [WD_W-1:0] width_ff, width_in;
   logic [HT_W-1:0] height_ff, height_in;
   logic            restart;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               restart = 1'b1;
               if (csr_wdata == '0) begin
                  width_in = WD_W'(1);
               end else if (32'(csr_wdata) > MAX_WIDTH) begin
                  width_in = WD_W'(MAX_WIDTH);
               end else begin
                  width_in = WD_W'(csr_wdata);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               restart = 1'b1;
               if (csr_wdata == '0) begin
                  height_in = HT_W'(1);
               end else if (32'(csr_wdata) > MAX_HEIGHT) begin
                  height_in = HT_W'(MAX_HEIGHT);
               end else begin
                  height_in = HT_W'(csr_wdata);
               end
            end
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: accept, frame position, line store read.
   // Row index runs 0..height; row == height is the flush row, in which
   // only flush items count. Items of the wrong kind are dropped here.
   // ------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [HT_W-1:0]  row_ff, row_in;

   logic        accept, act, at_flush_row, col_last, w_is1;
   res_ctl_type ctl0;
   logic        credit_ok;
   logic [1:0]  n1, n2;
   logic [RQ_CNT_W-1:0] rq_level;

   assign accept       = req_ch.valid && req_ch.ready;
   assign at_flush_row = (row_ff == height_ff);
   assign act          = accept && (req_ch.mode == at_flush_row);
   assign col_last     = (WD_W'(col_ff) == width_ff - WD_W'(1));
   assign w_is1        = (width_ff == WD_W'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (act) begin
         if (col_last) begin
            col_in = '0;
            row_in = at_flush_row ? '0 : row_ff + HT_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // item at (c, r) emits (c-1, r-1); at the last column also (W-1, r-1)
   always_comb begin
      ctl0.main    = (row_ff != '0) && !w_is1 && (col_ff != '0);
      ctl0.tail    = ctl0.main && col_last;
      ctl0.triple  = (row_ff != '0) && w_is1;
      ctl0.left_p1 = (col_ff == COL_W'(1));
      ctl0.fe      = req_ch.mode;
   end

   // room in the result queue for everything in flight plus two more
   assign credit_ok = ({1'b0, rq_level} + CR_W'(n1) + CR_W'(n2) + CR_W'(2))
                      <= CR_W'(RQ_DEPTH);
   assign req_ch.ready = credit_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WD_W'(W_RST);
         height_ff <= HT_W'(H_RST);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Line store: one entry per column, {row r-2, row r-1}. Read at
   // accept, written back in the next cycle from stage 1.
   // ------------------------------------------------------------------
   logic [MEM_W-1:0] row_mem [MAX_WIDTH];
   logic [MEM_W-1:0] row_rd_ff;
   logic             mem_wr_en;
   logic [MEM_W-1:0] mem_wr_data;

   // same column read while stage 1 writes it (single-column frame)
   logic             fwd_ff, fwd_in;
   logic [MEM_W-1:0] fwd_data_ff;

   logic [COL_W-1:0] s1_col_ff;

   assign fwd_in = act && mem_wr_en && (col_ff == s1_col_ff);

   always_ff @(posedge clock) begin
      if (act) begin
         row_rd_ff <= row_mem[col_ff];
      end
      if (mem_wr_en) begin
         row_mem[s1_col_ff] <= mem_wr_data;
      end
      fwd_data_ff <= mem_wr_data;
   end

   // ------------------------------------------------------------------
   // Stage 1: vertical 3-pixel sum of the column, window shift, writeback.
   // ------------------------------------------------------------------
   logic              s1_valid_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic              s1_flush_ff;
   logic              s1_rlow_ff;   // row <= 1: top clamps onto middle
   res_ctl_type       s1_ctl_ff;

   logic [MEM_W-1:0]  word;
   logic [PIX_W-1:0]  mid, top, bot;
   lanes_type         vsum;
   lanes_type         win0_ff, win0_in;
   lanes_type         win1_ff, win1_in;

   always_comb begin
      word        = fwd_ff ? fwd_data_ff : row_rd_ff;
      mid         = word[PIX_W-1:0];
      top         = s1_rlow_ff ? mid : word[MEM_W-1:PIX_W];
      bot         = s1_flush_ff ? mid : s1_pix_ff;
      vsum        = spread(top) + spread(mid) + spread(bot);
      mem_wr_en   = s1_valid_ff && !s1_flush_ff;
      mem_wr_data = {mid, s1_pix_ff};
      win0_in     = win0_ff;
      win1_in     = win1_ff;
      if (restart) begin
         win0_in = '0;
         win1_in = '0;
      end else if (s1_valid_ff) begin
         win0_in = vsum;
         win1_in = win0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         win0_ff     <= '0;
         win1_ff     <= '0;
      end else begin
         s1_valid_ff <= act;
         fwd_ff      <= fwd_in;
         win0_ff     <= win0_in;
         win1_ff     <= win1_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff   <= col_ff;
      s1_pix_ff   <= {req_ch.in_blue, req_ch.in_green, req_ch.in_red};
      s1_flush_ff <= req_ch.mode;
      s1_rlow_ff  <= (row_ff <= HT_W'(1));
      s1_ctl_ff   <= ctl0;
   end

   // ------------------------------------------------------------------
   // Stage 2: horizontal sums, push up to two results into the queue.
   // ------------------------------------------------------------------
   logic        s2_valid_ff;
   lanes_type   s2_v_ff, s2_p1_ff, s2_left_ff;
   res_ctl_type s2_ctl_ff;
   lanes_type   sum_main, sum_tail, sum_trip;
   rq_push_type push;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_v_ff    <= vsum;
      s2_p1_ff   <= win0_ff;
      s2_left_ff <= s1_ctl_ff.left_p1 ? win0_ff : win1_ff;
      s2_ctl_ff  <= s1_ctl_ff;
   end

   // lanes never carry into each other: nine samples stay below 4096
   always_comb begin
      sum_main = s2_left_ff + s2_p1_ff + s2_v_ff;
      sum_tail = s2_p1_ff + s2_v_ff + s2_v_ff;
      sum_trip = s2_v_ff + s2_v_ff + s2_v_ff;

      push.v0           = s2_valid_ff && (s2_ctl_ff.main || s2_ctl_ff.triple);
      push.e0.sum       = s2_ctl_ff.triple ? sum_trip : sum_main;
      push.e0.frame_end = s2_ctl_ff.triple && s2_ctl_ff.fe;
      push.e0.run_end   = !s2_ctl_ff.tail;
      push.v1           = s2_valid_ff && s2_ctl_ff.tail;
      push.e1.sum       = sum_tail;
      push.e1.frame_end = s2_ctl_ff.fe;
      push.e1.run_end   = 1'b1;
   end

   assign n1 = s1_valid_ff ? res_count(s1_ctl_ff) : 2'd0;
   assign n2 = s2_valid_ff ? res_count(s2_ctl_ff) : 2'd0;

   // queue, divide by nine, output register
   bbr_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .level  (rq_level),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- hw/rtl/bbr_checker.sv -----
`timescale 1ns / 1ps
`include "box_blur_3x3_rgb_defines.svh"
module bbr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_red,
   input logic [7:0] out_green,
   input logic [7:0] out_blue,
   input logic       frame_end,
   input logic       run_end
);

   logic req_seen;
   assign req_seen = req_valid && req_ready;

   `BBR_ASSERT_RESET(a_reset_quiet, reset, !rsp_valid, "result valid right after reset")
   `BBR_ASSERT_SAME(a_fe_last, rsp_valid && frame_end, run_end, "frame end not last of item")
   `BBR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `BBR_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready && !req_seen,
      $stable({out_red, out_green, out_blue, frame_end, run_end}), "stalled result changed")

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .out_red   (rsp_ch.out_red),
   .out_green (rsp_ch.out_green),
   .out_blue  (rsp_ch.out_blue),
   .frame_end (rsp_ch.frame_end),
   .run_end   (rsp_ch.run_end)
);

// ----- sim/box_blur_3x3_rgb_tb.sv -----
`timescale 1ns / 1ps
module box_blur_3x3_rgb_tb;
   import bbr_pkg::*;

   localparam int          CLK_PERIOD   = 10;
   localparam int          MAX_W        = 2048;
   localparam int          MAX_H        = 2048;
   // settle time after the last expected result; pad generously
   localparam int          DRAIN_CYCLES = 12;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;

   // one blurred output pixel as seen on rsp
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
      logic       run_end;
   } blur_px_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bbr_req_if req_ch ();
   bbr_rsp_if rsp_ch ();

   box_blur_3x3_rgb #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------
   // Blur predictor: own copy of the line stores, window and counters
   // ---------------------------------------------------------------
   logic [11:0] cfg_width;
   logic [11:0] cfg_height;
   logic [23:0] older_row [0:MAX_W-1];   // row r-2
   logic [23:0] newer_row [0:MAX_W-1];   // row r-1
   lanes_type   vsum_last;               // vertical sum of column c-1
   lanes_type   vsum_older;              // vertical sum of column c-2
   int unsigned col_pos;
   int unsigned row_pos;

   blur_px_type blurred_pending [$];     // expected rsp items, oldest first
   blur_px_type blur_head;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // stall controls, in percent of cycles
   int unsigned src_idle_pct   = 0;
   int unsigned sink_stall_pct = 0;

   // zero acts as 1, anything above the maximum acts as the maximum
   function automatic int unsigned eff_dim(input logic [11:0] v, input int unsigned maxv);
      if (v == 12'd0) return 1;
      return (v > maxv) ? maxv : int'(v);
   endfunction

   // 8-bit channels into 12-bit lanes: red low, blue high
   function automatic lanes_type to_lanes(input logic [23:0] p);
      lanes_type l;
      l = '0;
      l[7:0]   = p[7:0];
      l[19:12] = p[15:8];
      l[31:24] = p[23:16];
      return l;
   endfunction

   function automatic void push_blur(input lanes_type s, input logic fe, input logic re);
      blur_px_type px;
      logic [11:0] q_r, q_g, q_b;
      q_r = s[11:0] / 12'd9;
      q_g = s[23:12] / 12'd9;
      q_b = s[35:24] / 12'd9;
      px.red       = q_r[7:0];
      px.green     = q_g[7:0];
      px.blue      = q_b[7:0];
      px.frame_end = fe;
      px.run_end   = re;
      blurred_pending.push_back(px);
   endfunction

   function automatic void restart_position();
      vsum_last  = '0;
      vsum_older = '0;
      col_pos    = 0;
      row_pos    = 0;
   endfunction

   function automatic void predictor_reset();
      cfg_width  = 12'd640;
      cfg_height = 12'd480;
      for (int i = 0; i < MAX_W; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      restart_position();
   endfunction

   // expected results of one accepted item
   function automatic void predict_blur(input logic is_flush, input logic [23:0] pix);
      int unsigned w, h, c, r;
      logic [23:0] mid, top, bot;
      lanes_type   v, p1, p2, left;
      w = eff_dim(cfg_width, MAX_W);
      h = eff_dim(cfg_height, MAX_H);
      if (col_pos >= w || row_pos > h) restart_position();
      c = col_pos;
      r = row_pos;
      // flush before the last pixel, or pixel inside the flush row: no effect
      if (is_flush != (r == h)) return;
      mid = newer_row[c];
      top = (r <= 1) ? mid : older_row[c];
      bot = is_flush ? mid : pix;
      v   = to_lanes(top) + to_lanes(mid) + to_lanes(bot);
      p1  = vsum_last;
      p2  = vsum_older;
      if (r >= 1) begin
         if (w == 1) begin
            push_blur(v + v + v, is_flush, 1'b1);
         end else if (c >= 1) begin
            // left edge clamps onto column 0
            left = (c == 1) ? p1 : p2;
            push_blur(left + p1 + v, 1'b0, c != w - 1);
            // right edge replicates the last column
            if (c == w - 1) push_blur(p1 + v + v, is_flush, 1'b1);
         end
      end
      if (!is_flush) begin
         older_row[c] = newer_row[c];
         newer_row[c] = pix;
      end
      vsum_older = p1;
      vsum_last  = v;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      col_pos = c;
      row_pos = r;
      // past the flush row: next frame starts
      if (r > h) restart_position();
   endfunction

   // ---------------------------------------------------------------
   // Result side: random ready, compare against oldest expectation
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (blurred_pending.size() == 0) begin
            $error("result item with nothing expected: r=%0d g=%0d b=%0d",
                   rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue);
            error_count++;
         end else begin
            blur_head = blurred_pending.pop_front();
            check_field("out_red",   blur_head.red,   rsp_ch.out_red);
            check_field("out_green", blur_head.green, rsp_ch.out_green);
            check_field("out_blue",  blur_head.blue,  rsp_ch.out_blue);
            check_field("frame_end", {7'd0, blur_head.frame_end}, {7'd0, rsp_ch.frame_end});
            check_field("run_end",   {7'd0, blur_head.run_end},   {7'd0, rsp_ch.run_end});
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   // one item on req; random idle cycles ahead of it, predicted on accept
   task automatic send_item(input logic is_flush, input logic [23:0] pix);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= is_flush;
      req_ch.in_red   <= pix[7:0];
      req_ch.in_green <= pix[15:8];
      req_ch.in_blue  <= pix[23:16];
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_blur(is_flush, pix);
   endtask

   // drop valid, let all expected results out, then cover trailing work
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (blurred_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both registers, block idle; each write restarts the frame position
   task automatic write_dims(input logic [11:0] w, input logic [11:0] h);
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_we    <= 1'b0;
      cfg_width  = w;
      cfg_height = h;
      restart_position();
   endtask

   // channel values biased toward the extremes
   function automatic logic [7:0] rand_channel();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [23:0] rand_pixel();
      return {rand_channel(), rand_channel(), rand_channel()};
   endfunction

   // mostly small sizes, sometimes zero, now and then mid-size
   function automatic logic [11:0] rand_dim(input int unsigned typ);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 4) return 12'd0;
      if (pick < 10) return 12'($urandom_range(40, typ + 1));
      return 12'($urandom_range(typ, 1));
   endfunction

   // one frame at the current size; ignored items sprinkled in at noise_pct;
   // abort stops at a random item, caller must restart with a register write
   task automatic send_frame(input int unsigned noise_pct, input bit abort,
                             output int unsigned counted);
      int unsigned w, h, total, stop_at;
      w       = eff_dim(cfg_width, MAX_W);
      h       = eff_dim(cfg_height, MAX_H);
      total   = w * h + w;
      stop_at = abort ? $urandom_range(total - 1, 0) : total;
      counted = 0;
      for (int unsigned idx = 0; idx < total; idx++) begin
         if (idx < w * h) begin
            // stray flush while pixels are still due
            if ($urandom_range(99) < noise_pct) send_item(1'b1, rand_pixel());
            send_item(1'b0, rand_pixel());
         end else begin
            // stray pixel inside the flush row
            if ($urandom_range(99) < noise_pct) send_item(1'b0, rand_pixel());
            send_item(1'b1, rand_pixel());
         end
         counted++;
         if (idx == stop_at) return;
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // single-pixel frame from zero registers, stray items, pixel extremes in 3 x 2 and 2 x 3 frames
   task automatic test_directed_edges();
      // 0 x 0 acts as 1 x 1
      write_dims(12'd0, 12'd0);
      send_item(1'b1, 24'h123456);      // flush before the pixel: ignored
      send_item(1'b0, 24'hFFFFFF);
      send_item(1'b0, 24'h000000);      // pixel in flush row: ignored
      send_item(1'b1, 24'hABCDEF);
      // 3 x 2 checkerboard of black and white
      write_dims(12'd3, 12'd2);
      for (int i = 0; i < 6; i++) send_item(1'b0, (i % 2) ? 24'hFFFFFF : 24'h000000);
      for (int i = 0; i < 3; i++) send_item(1'b1, 24'h000000);
      // 2 x 3: red saturated, green zero, blue ramp
      write_dims(12'd2, 12'd3);
      for (int i = 0; i < 6; i++) send_item(1'b0, {8'(i * 51), 8'h00, 8'hFF});
      for (int i = 0; i < 2; i++) send_item(1'b1, 24'hFFFFFF);
   endtask

   // well-formed frames with random content, some noise and aborted frames
   task automatic test_random_frames(input int unsigned item_budget);
      int unsigned done_items, n;
      bit          need_cfg, abort;
      done_items = 0;
      need_cfg   = 1'b1;
      while (done_items < item_budget) begin
         if (need_cfg || $urandom_range(99) < 40) write_dims(rand_dim(12), rand_dim(8));
         abort = ($urandom_range(99) < 8);
         send_frame(5, abort, n);
         done_items += n;
         need_cfg = abort;
      end
   endtask

   // register values above the maximum, partial frames each restarted by a write, zero height
   task automatic test_dimension_limits();
      int unsigned n;
      // tall single column: every pixel after the first row releases one result
      write_dims(12'd1, 12'hFFF);
      for (int i = 0; i < 150; i++) send_item(1'b0, rand_pixel());
      // widest row: nothing released inside the first row, stray flush ignored
      write_dims(12'hFFF, 12'hFFF);
      for (int i = 0; i < 48; i++) send_item(1'b0, rand_pixel());
      send_item(1'b1, rand_pixel());
      // zero height acts as one row
      write_dims(12'd4, 12'd0);
      send_frame(0, 1'b0, n);
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.mode     = 1'b0;
      req_ch.in_red   = 8'd0;
      req_ch.in_green = 8'd0;
      req_ch.in_blue  = 8'd0;
      rsp_ch.ready    = 1'b0;
      csr_we          = 1'b0;
      csr_index       = CSR_IMAGE_WIDTH;
      csr_wdata       = '0;
      predictor_reset();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver stalls hard
      src_idle_pct   = 14;
      sink_stall_pct = 54;
      test_directed_edges();
      test_random_frames(380);

      // the other way round
      src_idle_pct   = 54;
      sink_stall_pct = 14;
      test_random_frames(380);

      // full rate both sides
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      test_random_frames(380);
      test_dimension_limits();

      wait_drained();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
